// File: rtl/stbs_pkg.sv
// shared types and constants for the sorted table binary search block
package stbs_pkg;

	localparam int DEPTH_DEF = 1024;

	localparam int OPCODE_W = 1;
	localparam int INDEX_W = 10;
	localparam int VALUE_W = 32;
	localparam int SIZE_W = 11;
	localparam int POS_W = 10;

	localparam logic [OPCODE_W-1:0] OP_WRITE = 1'b0;
	localparam logic [OPCODE_W-1:0] OP_SEARCH = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CMP
	} stbs_state_t;

endpackage

// File: rtl/stbs_ram.sv
// table memory: one write port, one registered read port
module stbs_ram import stbs_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  logic [VALUE_W-1:0] wr_data,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	output logic [VALUE_W-1:0] rd_data
);

	logic [VALUE_W-1:0] mem_q [DEPTH];
	logic [VALUE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/sorted_table_binary_search.sv
// top level: sorted table with binary search over a synchronous memory
// a write request gives no result; writes can follow every cycle while no search is
// in progress; a search request runs one probe after another until a hit or an empty
// range; each probe is one memory read followed by one compare
// one search at a time; a full result register stalls it
// arst_n clears control state and table_size; table contents are undefined until written
module sorted_table_binary_search import stbs_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration: table_size
	input  logic                cfg_we,
	input  logic [SIZE_W-1:0]   cfg_wdata,
	// request channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OPCODE_W-1:0] opcode,
	input  logic [INDEX_W-1:0]  entry_index,
	input  logic [VALUE_W-1:0]  value,
	// result channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic                found,
	output logic [POS_W-1:0]    position
);

	// address width and width of a range bound (bounds reach DEPTH itself)
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int HW = $clog2(DEPTH + 1);

	stbs_state_t state_q, state_nx;

	logic [SIZE_W-1:0]  table_size_q;
	logic [HW-1:0]      lo_q, hi_q;
	logic [AW-1:0]      mid_q;
	logic [VALUE_W-1:0] key_q;

	logic               out_valid_q;
	logic               found_q;
	logic [POS_W-1:0]   position_q;

	// memory control
	logic               wr_en, rd_en;
	logic [AW-1:0]      wr_addr, rd_addr;
	logic [VALUE_W-1:0] rd_data;

	// datapath
	logic               req_acc;
	logic               out_free;
	logic               idx_ok;
	logic [31:0]        size_w, size_sat;
	logic [HW-1:0]      hi_init;
	logic [HW:0]        mid_sum;
	logic [HW-1:0]      mid;
	logic               range_empty;
	logic               cmp_eq, cmp_gt;
	logic               finish;
	logic               finish_found;
	logic [POS_W-1:0]   finish_pos;

	assign in_ready = (state_q == ST_IDLE);
	assign req_acc  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// writes beyond the table depth are dropped
	assign idx_ok = (32'(entry_index) < 32'(DEPTH));

	// table_size saturates at the depth
	assign size_w   = 32'(table_size_q);
	assign size_sat = (size_w > 32'(DEPTH)) ? 32'(DEPTH) : size_w;
	assign hi_init  = size_sat[HW-1:0];

	// midpoint of [lo, hi) rounded down; only used while lo < hi
	assign mid_sum     = {1'b0, lo_q} + {1'b0, hi_q} - {{HW{1'b0}}, 1'b1};
	assign mid         = mid_sum[HW:1];
	assign range_empty = !(lo_q < hi_q);

	// signed compare of the probed entry against the key
	assign cmp_eq = (rd_data == key_q);
	assign cmp_gt = ($signed(rd_data) > $signed(key_q));

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_acc && (opcode == OP_SEARCH)) begin
					state_nx = ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (range_empty) begin
					if (out_free) begin
						state_nx = ST_IDLE;
					end
				end else begin
					state_nx = ST_CMP;
				end
			end
			ST_CMP: begin
				if (cmp_eq) begin
					if (out_free) begin
						state_nx = ST_IDLE;
					end
				end else begin
					state_nx = ST_PROBE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// memory and result control
	always_comb begin
		wr_en        = 1'b0;
		wr_addr      = AW'(32'(entry_index));
		rd_en        = 1'b0;
		rd_addr      = mid[AW-1:0];
		finish       = 1'b0;
		finish_found = 1'b0;
		finish_pos   = POS_W'(32'(mid_q));
		case (state_q)
			ST_IDLE: begin
				wr_en = req_acc && (opcode == OP_WRITE) && idx_ok;
			end
			ST_PROBE: begin
				if (range_empty) begin
					finish = out_free;
				end else begin
					rd_en = 1'b1;
				end
			end
			ST_CMP: begin
				if (cmp_eq) begin
					finish       = out_free;
					finish_found = 1'b1;
				end
			end
			default: begin
				finish = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			table_size_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				table_size_q <= cfg_wdata;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// search bounds, key and probe index
	always_ff @(posedge clk) begin
		if (req_acc && (opcode == OP_SEARCH)) begin
			lo_q  <= '0;
			hi_q  <= hi_init;
			key_q <= value;
		end
		if (state_q == ST_PROBE && !range_empty) begin
			mid_q <= mid[AW-1:0];
		end
		if (state_q == ST_CMP && !cmp_eq) begin
			if (cmp_gt) begin
				hi_q <= HW'(32'(mid_q));
			end else begin
				lo_q <= HW'(32'(mid_q) + 32'd1);
			end
		end
	end

	// result register; position reads 0 when not found
	always_ff @(posedge clk) begin
		if (finish) begin
			found_q    <= finish_found;
			position_q <= finish_found ? finish_pos : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign position  = position_q;

	stbs_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule

// File: sim/sorted_table_binary_search_tb.sv
// testbench for the sorted table binary search block: directed and random requests
`timescale 1ns / 100ps

module sorted_table_binary_search_tb import stbs_pkg::*;;

	localparam int CLK_HALF = 10;
	localparam int DRAIN_CYCLES = 30;
	localparam logic signed [VALUE_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

	// how a table is filled before it is searched
	typedef enum int {
		FILL_DENSE,     // small steps, many repeated keys
		FILL_WIDE,      // steps spread over the whole signed range
		FILL_SHUFFLED   // random order, table not sorted
	} fill_kind_t;

	typedef struct packed {
		logic            hit;
		logic [POS_W-1:0] pos;
	} search_result_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [SIZE_W-1:0]   cfg_wdata;
	logic                in_valid;
	logic                in_ready;
	logic [OPCODE_W-1:0] opcode;
	logic [INDEX_W-1:0]  entry_index;
	logic [VALUE_W-1:0]  value;
	logic                out_valid;
	logic                out_ready;
	logic                found;
	logic [POS_W-1:0]    position;

	// own copy of the table and of table_size, updated as writes are accepted and table_size is set
	logic signed [VALUE_W-1:0] table_model [DEPTH_DEF];
	logic [SIZE_W-1:0]         size_model;
	search_result_t            pending_results [$];

	int err_count;
	int requests_sent;
	int searches_sent;
	int results_checked;
	int hits_seen;
	int out_hold;
	bit steady_flow;   // when set neither side idles

	sorted_table_binary_search #(
		.DEPTH(DEPTH_DEF)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.entry_index (entry_index),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.position    (position)
	);

	always begin
		clk = 1'b0;
		#CLK_HALF;
		clk = 1'b1;
		#CLK_HALF;
	end

	// binary search over the modeled table: range [lo, hi), midpoint rounded down
	function automatic search_result_t predict_search(input logic signed [VALUE_W-1:0] key);
		search_result_t r;
		int lo;
		int hi;
		int mid;
		r.hit = 1'b0;
		r.pos = '0;
		lo = 0;
		hi = (size_model > DEPTH_DEF) ? DEPTH_DEF : int'(size_model);
		while (lo < hi) begin
			mid = (lo + hi - 1) / 2;
			if (table_model[mid] == key) begin
				r.hit = 1'b1;
				r.pos = mid[POS_W-1:0];
				lo = hi;   // first equal entry in probe order wins
			end else if (table_model[mid] > key) begin
				hi = mid;
			end else begin
				lo = mid + 1;
			end
		end
		return r;
	endfunction

	task automatic report_failure(input string msg);
		err_count++;
		if (err_count <= 10) begin
			$display("[%0t] %s", $realtime, msg);
		end
	endtask

	// one request: optional idle gap, then hold valid until accepted
	// valid is left high after acceptance; the next call or the drain drops or reuses it
	task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [INDEX_W-1:0] idx,
			input logic [VALUE_W-1:0] val);
		int gap;
		gap = steady_flow ? 0 : $urandom_range(0, 11);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		entry_index <= idx;
		value <= val;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		requests_sent++;
		if (op == OP_WRITE) begin
			table_model[idx] = val;
		end else begin
			pending_results = {pending_results, predict_search(val)};
			searches_sent++;
		end
	endtask

	// drop valid, wait for every search result, then let a trailing write settle
	task automatic wait_until_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// table_size is only written while the block is idle
	task automatic set_table_size(input int n);
		wait_until_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= n[SIZE_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		size_model = n[SIZE_W-1:0];
	endtask

	// writes entries 0 to n-1 so no search can probe an unwritten entry
	task automatic load_table(input int n, input fill_kind_t kind);
		longint cur;
		longint step_max;
		if (kind == FILL_DENSE) begin
			step_max = 3;
			cur = -64'sd2147483648 + longint'($urandom_range(0, 32'hFFFF_0000));
		end else begin
			step_max = 64'h0_FFFF_FFFF / ((n > 0) ? n : 1);
			cur = -64'sd2147483648 + longint'($urandom_range(0, step_max[31:0]));
		end
		for (int i = 0; i < n; i++) begin
			if (kind == FILL_SHUFFLED) begin
				send_request(OP_WRITE, i[INDEX_W-1:0], $urandom);
			end else begin
				send_request(OP_WRITE, i[INDEX_W-1:0], cur[VALUE_W-1:0]);
				cur += longint'($urandom_range(0, step_max[31:0]));
			end
		end
	endtask

	// mostly searches for keys near the table contents, some extremes, a few stray writes
	task automatic random_request(input int n);
		int eff;
		int pick;
		logic signed [VALUE_W-1:0] key;
		eff = (n > DEPTH_DEF) ? DEPTH_DEF : n;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			send_request(OP_WRITE, INDEX_W'($urandom_range(0, DEPTH_DEF - 1)), $urandom);
		end else begin
			if (eff > 0 && pick < 60) begin
				key = table_model[$urandom_range(0, eff - 1)];
			end else if (eff > 0 && pick < 75) begin
				key = table_model[$urandom_range(0, eff - 1)] + ($urandom_range(0, 1) ? 1 : -1);
			end else if (pick < 85) begin
				key = $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
			end else begin
				key = $urandom;
			end
			send_request(OP_SEARCH, INDEX_W'($urandom_range(0, DEPTH_DEF - 1)), key);
		end
	endtask

	// size zero: nothing to probe, so never found
	task automatic test_empty_table();
		send_request(OP_SEARCH, '0, 32'd0);
		set_table_size(0);
		send_request(OP_SEARCH, '1, KEY_MIN);
		send_request(OP_SEARCH, '0, KEY_MAX);
	endtask

	// extreme values and extreme indexes, single entry and short tables
	task automatic test_table_edges();
		send_request(OP_WRITE, 10'd0, KEY_MIN);
		send_request(OP_WRITE, 10'd1, -32'sd1);
		send_request(OP_WRITE, 10'd2, 32'sd0);
		send_request(OP_WRITE, 10'd3, KEY_MAX);
		send_request(OP_WRITE, 10'd1023, KEY_MAX);
		set_table_size(1);
		send_request(OP_SEARCH, 10'd0, KEY_MIN);
		send_request(OP_SEARCH, 10'd1023, KEY_MAX);
		set_table_size(4);
		send_request(OP_SEARCH, 10'd0, KEY_MIN);
		send_request(OP_SEARCH, 10'd0, KEY_MAX);
		send_request(OP_SEARCH, 10'd0, -32'sd1);
		send_request(OP_SEARCH, 10'd0, 32'sd5);
	endtask

	// repeated keys: the first equal midpoint is reported, not the leftmost
	task automatic test_repeated_keys();
		send_request(OP_WRITE, 10'd0, 32'sd7);
		send_request(OP_WRITE, 10'd1, 32'sd7);
		send_request(OP_WRITE, 10'd2, 32'sd7);
		send_request(OP_WRITE, 10'd3, 32'sd9);
		send_request(OP_SEARCH, 10'd0, 32'sd7);
		send_request(OP_SEARCH, 10'd0, 32'sd9);
	endtask

	// unsorted contents: the probe rule is followed blindly
	task automatic test_unsorted_table();
		send_request(OP_WRITE, 10'd0, 32'sd50);
		send_request(OP_WRITE, 10'd1, -32'sd3);
		send_request(OP_WRITE, 10'd2, 32'sd20);
		send_request(OP_WRITE, 10'd3, -32'sd100);
		send_request(OP_SEARCH, 10'd0, -32'sd100);
		send_request(OP_SEARCH, 10'd0, 32'sd20);
	endtask

	// short tables of many shapes, refilled after every size change
	task automatic test_random_small_tables();
		int n;
		int k;
		fill_kind_t kind;
		for (int p = 0; p < 10; p++) begin
			n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 30);
			k = $urandom_range(0, 9);
			kind = (k == 0) ? FILL_SHUFFLED : ((k < 5) ? FILL_DENSE : FILL_WIDE);
			steady_flow = ($urandom_range(0, 3) == 0);
			set_table_size(n);
			load_table(n, kind);
			repeat (20) random_request(n);
		end
	endtask

	// whole table in use, sizes just below, at and above the depth
	task automatic test_full_table();
		steady_flow = 1'b0;
		set_table_size(DEPTH_DEF);
		load_table(DEPTH_DEF, FILL_WIDE);
		repeat (20) random_request(DEPTH_DEF);
		set_table_size(DEPTH_DEF - 1);
		repeat (15) random_request(DEPTH_DEF - 1);
		steady_flow = 1'b1;
		set_table_size(2047);   // all ones, saturates to the depth
		repeat (15) random_request(2047);
		steady_flow = 1'b0;
		set_table_size(1100);
		repeat (10) random_request(1100);
	endtask

	// result side: random stall after each result, ready changes on the falling edge
	always @(negedge clk) begin
		if (out_hold > 0) begin
			out_ready <= 1'b0;
			out_hold = out_hold - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// compare every accepted result with the oldest predicted one
	always @(posedge clk) begin : check_results
		search_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_failure($sformatf("result with no search pending: found=%0d position=%0d",
					found, position));
			end else begin
				exp_r = pending_results.pop_front();
				if (found !== exp_r.hit || position !== exp_r.pos) begin
					report_failure($sformatf("search %0d: exp found=%0d pos=%0d, got %0d %0d",
						results_checked, exp_r.hit, exp_r.pos, found, position));
				end
				if (exp_r.hit) begin
					hits_seen++;
				end
			end
			results_checked++;
			out_hold = steady_flow ? 0 : $urandom_range(0, 11);
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		opcode = OP_WRITE;
		entry_index = '0;
		value = '0;
		out_ready = 1'b0;
		out_hold = 0;
		steady_flow = 1'b0;
		err_count = 0;
		requests_sent = 0;
		searches_sent = 0;
		results_checked = 0;
		hits_seen = 0;
		size_model = '0;
		for (int i = 0; i < DEPTH_DEF; i++) begin
			table_model[i] = '0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_table_edges();
		test_repeated_keys();
		test_unsorted_table();
		test_random_small_tables();
		test_full_table();
		wait_until_idle();

		$display("covered %0d requests, %0d of them searches; %0d results compared, %0d hits",
			requests_sent, searches_sent, results_checked, hits_seen);
		$display("table sizes from empty through full depth and saturated, %0d failures",
			err_count);
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin : watchdog
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
